// File: hdl/stereo_lookahead_peak_limiter_core_macros.svh
// assertion macros shared by the limiter rtl
// every macro samples on clk and is switched off while rst is high
`ifndef STEREO_LOOKAHEAD_PEAK_LIMITER_CORE_MACROS_SVH
`define STEREO_LOOKAHEAD_PEAK_LIMITER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SLPL_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("slpl: invariant violated");

`define SLPL_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slpl: implication violated");

`define SLPL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slpl: next-cycle check violated");

`else

`define SLPL_ASSERT_ALWAYS(lbl, expr)
`define SLPL_ASSERT_IMPLY(lbl, ante, cons)
`define SLPL_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: hdl/slpl_pkg.sv
`default_nettype none

package slpl_pkg;

  localparam int MAX_LOOKAHEAD = 256;
  localparam int PTR_W = (MAX_LOOKAHEAD > 1) ? $clog2(MAX_LOOKAHEAD) : 1;
  localparam int LEN_W = 9;
  // wide enough for both the register value and the store depth
  localparam int CLEN_W = ($clog2(MAX_LOOKAHEAD + 1) > LEN_W) ?
                          $clog2(MAX_LOOKAHEAD + 1) : LEN_W;

  localparam int SAMPLE_W = 32;
  localparam int FRAME_W = 2 * SAMPLE_W;
  localparam int THRESH_W = 31;
  localparam int COEFF_W = 15;
  localparam int GAIN_Q14_W = 15;
  localparam int CFG_DATA_W = 31;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_DATA_W = 80;

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 24;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [30:0] UNITY_Q30 = 31'h4000_0000;
  localparam logic [30:0] THRESH_RESET = 31'h0800_0000;
  localparam logic [LEN_W-1:0] LOOKAHEAD_RESET = 9'd256;
  localparam logic [14:0] C035_Q15 = 15'd11469;
  localparam logic [15:0] C085_Q15 = 16'd27853;
  localparam logic [16:0] HALF_Q16 = 17'd32768;
  localparam logic [2:0] NORM_LAST = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD,
    CFG_ATTACK,
    CFG_RELEASE,
    CFG_LOOKAHEAD
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PEAK,
    ST_CMP,
    ST_NORM,
    ST_MUL1,
    ST_MUL2,
    ST_INV,
    ST_MUL3,
    ST_CLAMP,
    ST_DIFF,
    ST_MULS,
    ST_UPD,
    ST_MULL,
    ST_MULR,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    MS_FRAC_C035,
    MS_FRAC_POLY,
    MS_THR_SCALE,
    MS_COEFF_DIFF,
    MS_GAIN_LEFT,
    MS_GAIN_RIGHT
  } mul_sel_t;

  typedef struct packed {
    logic     in_ready;
    logic     load_peak;
    logic     check;
    logic     norm;
    logic [2:0] norm_step;
    logic     load_inv;
    logic     load_tgt;
    logic     load_diff;
    logic     load_gain;
    logic     load_left;
    logic     finish;
    logic     mul_en;
    mul_sel_t mul_sel;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic above;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// File: hdl/slpl_mul.sv
`default_nettype none

module slpl_mul (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire logic signed [slpl_pkg::MUL_A_W-1:0]  a,
  input  wire logic signed [slpl_pkg::MUL_B_W-1:0]  b,
  output logic signed [slpl_pkg::MUL_P_W-1:0]       p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= a * b;
    end
  end

endmodule

`default_nettype wire

// File: hdl/slpl_delay.sv
`default_nettype none

module slpl_delay (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              rd_en,
  input  wire logic [slpl_pkg::LEN_W-1:0]        len,
  input  wire logic                              wr_en,
  input  wire logic [slpl_pkg::FRAME_W-1:0]      wr_data,
  output logic [slpl_pkg::FRAME_W-1:0]           rd_data
);

  localparam int CW = slpl_pkg::CLEN_W;
  localparam int PW = slpl_pkg::PTR_W;
  localparam int DEPTH = slpl_pkg::MAX_LOOKAHEAD;

  logic [slpl_pkg::FRAME_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]             valid;
  logic [PW-1:0]                ptr;
  logic [PW-1:0]                ptr_next;
  logic [PW-1:0]                rd_addr;
  logic [CW-1:0]                len_ext;
  logic [CW-1:0]                len_c;
  logic [slpl_pkg::FRAME_W-1:0] rdata;
  logic                         rvalid;

  always_comb begin
    len_ext = CW'(len);
    len_c = (len_ext > CW'(DEPTH)) ? CW'(DEPTH) : len_ext;
    if (CW'(ptr) >= len_c) begin
      rd_addr = PW'(CW'(ptr) - len_c);
    end else begin
      rd_addr = PW'((CW'(DEPTH) - len_c) + CW'(ptr));
    end
    ptr_next = (ptr == PW'(DEPTH - 1)) ? '0 : ptr + PW'(1);
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[ptr] <= wr_data;
    end
  end

  // entries never written read back as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      ptr <= '0;
      rvalid <= 1'b0;
    end else begin
      if (rd_en) begin
        rvalid <= valid[rd_addr];
      end
      if (wr_en) begin
        valid[ptr] <= 1'b1;
        ptr <= ptr_next;
      end
    end
  end

  assign rd_data = rvalid ? rdata : '0;

endmodule

`default_nettype wire

// File: hdl/slpl_fsm.sv
`default_nettype none

module slpl_fsm (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire slpl_pkg::stat_t stat,
  output slpl_pkg::ctrl_t      ctrl
);

  slpl_pkg::state_t state;
  slpl_pkg::state_t state_next;
  logic [2:0]       step;
  logic [2:0]       step_next;

  always_comb begin
    state_next = state;
    step_next = '0;
    unique case (state)
      slpl_pkg::ST_IDLE:  if (stat.in_valid) state_next = slpl_pkg::ST_PEAK;
      slpl_pkg::ST_PEAK:  state_next = slpl_pkg::ST_CMP;
      slpl_pkg::ST_CMP:   state_next = stat.above ? slpl_pkg::ST_NORM : slpl_pkg::ST_DIFF;
      slpl_pkg::ST_NORM: begin
        if (step == slpl_pkg::NORM_LAST) begin
          state_next = slpl_pkg::ST_MUL1;
        end else begin
          step_next = step + 3'd1;
        end
      end
      slpl_pkg::ST_MUL1:  state_next = slpl_pkg::ST_MUL2;
      slpl_pkg::ST_MUL2:  state_next = slpl_pkg::ST_INV;
      slpl_pkg::ST_INV:   state_next = slpl_pkg::ST_MUL3;
      slpl_pkg::ST_MUL3:  state_next = slpl_pkg::ST_CLAMP;
      slpl_pkg::ST_CLAMP: state_next = slpl_pkg::ST_DIFF;
      slpl_pkg::ST_DIFF:  state_next = slpl_pkg::ST_MULS;
      slpl_pkg::ST_MULS:  state_next = slpl_pkg::ST_UPD;
      slpl_pkg::ST_UPD:   state_next = slpl_pkg::ST_MULL;
      slpl_pkg::ST_MULL:  state_next = slpl_pkg::ST_MULR;
      slpl_pkg::ST_MULR:  state_next = slpl_pkg::ST_DONE;
      slpl_pkg::ST_DONE:  if (stat.out_free) state_next = slpl_pkg::ST_IDLE;
      default:            state_next = slpl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    ctrl.norm_step = step;
    unique case (state)
      slpl_pkg::ST_IDLE:  ctrl.in_ready = 1'b1;
      slpl_pkg::ST_PEAK:  ctrl.load_peak = 1'b1;
      slpl_pkg::ST_CMP:   ctrl.check = 1'b1;
      slpl_pkg::ST_NORM:  ctrl.norm = 1'b1;
      slpl_pkg::ST_MUL1: begin
        ctrl.mul_en = 1'b1;
        ctrl.mul_sel = slpl_pkg::MS_FRAC_C035;
      end
      slpl_pkg::ST_MUL2: begin
        ctrl.mul_en = 1'b1;
        ctrl.mul_sel = slpl_pkg::MS_FRAC_POLY;
      end
      slpl_pkg::ST_INV:   ctrl.load_inv = 1'b1;
      slpl_pkg::ST_MUL3: begin
        ctrl.mul_en = 1'b1;
        ctrl.mul_sel = slpl_pkg::MS_THR_SCALE;
      end
      slpl_pkg::ST_CLAMP: ctrl.load_tgt = 1'b1;
      slpl_pkg::ST_DIFF:  ctrl.load_diff = 1'b1;
      slpl_pkg::ST_MULS: begin
        ctrl.mul_en = 1'b1;
        ctrl.mul_sel = slpl_pkg::MS_COEFF_DIFF;
      end
      slpl_pkg::ST_UPD:   ctrl.load_gain = 1'b1;
      slpl_pkg::ST_MULL: begin
        ctrl.mul_en = 1'b1;
        ctrl.mul_sel = slpl_pkg::MS_GAIN_LEFT;
      end
      slpl_pkg::ST_MULR: begin
        ctrl.mul_en = 1'b1;
        ctrl.mul_sel = slpl_pkg::MS_GAIN_RIGHT;
        ctrl.load_left = 1'b1;
      end
      slpl_pkg::ST_DONE:  ctrl.finish = stat.out_free;
      default:            ctrl.in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slpl_pkg::ST_IDLE;
      step <= '0;
    end else begin
      state <= state_next;
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/stereo_lookahead_peak_limiter_core.sv
// stereo look-ahead peak limiter
//
// s_tdata carries one stereo frame; m_tdata returns one frame of the delayed
// audio scaled by the smoothed gain, plus the gain itself. cfg_we/cfg_index/
// cfg_data write threshold, attack, release and lookahead length; write them
// only while no item is in flight.
//
// one item at a time through a sequencer around a single shared 33x24
// multiplier. above threshold an item also passes the five-step leading zero
// search, the reciprocal polynomial and the threshold scaling, the last two on
// the same multiplier. the result shows on m_tvalid in the cycle after the
// last step.
//
// reset restores the register defaults, unity gain and an empty delay store
// (per-entry valid bits, so no clearing pass). a finished result waits in the
// output register while s_tready is already high again; if the receiver still
// holds off when the next item is done, the block stalls in its last step.
`default_nettype none

`include "stereo_lookahead_peak_limiter_core_macros.svh"

module stereo_lookahead_peak_limiter_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // [31:0] left_in, [63:32] right_in
  input  wire logic [slpl_pkg::FRAME_W-1:0]        s_tdata,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // [31:0] left_out, [63:32] right_out, [78:64] gain_q14, [79] zero
  output logic [slpl_pkg::OUT_DATA_W-1:0]          m_tdata,
  input  wire logic                                cfg_we,
  input  wire logic [slpl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [slpl_pkg::CFG_DATA_W-1:0]     cfg_data
);

  slpl_pkg::ctrl_t ctrl;
  slpl_pkg::stat_t stat;

  logic [slpl_pkg::THRESH_W-1:0] threshold;
  logic [slpl_pkg::COEFF_W-1:0]  attack_coeff;
  logic [slpl_pkg::COEFF_W-1:0]  release_coeff;
  logic [slpl_pkg::LEN_W-1:0]    lookahead_len;

  logic [31:0] l_in;
  logic [31:0] r_in;
  logic [30:0] peak;
  logic [30:0] norm;
  logic [4:0]  z;
  logic [15:0] scaled;
  logic [30:0] tgt;
  logic signed [31:0] diff;
  logic [slpl_pkg::COEFF_W-1:0] coeff;
  logic [30:0] sg;
  logic [31:0] left_res;

  logic accept;
  logic [31:0] mag_l;
  logic [31:0] mag_r;
  logic [30:0] sat_l;
  logic [30:0] sat_r;
  logic [30:0] peak_next;
  logic [4:0]  shamt;
  logic        top_zero;
  logic [16:0] inv17;
  logic [15:0] inv;
  logic [4:0]  e;
  logic [39:0] lim;
  logic signed [16:0] fdiff;
  logic signed [31:0] delta;
  logic signed [32:0] sum;
  logic [30:0] sg_next;
  logic [14:0] g14;
  logic        zero_len;
  logic [slpl_pkg::FRAME_W-1:0] mem_rd;
  logic [31:0] dl;
  logic [31:0] dr;

  logic signed [slpl_pkg::MUL_A_W-1:0] mul_a;
  logic signed [slpl_pkg::MUL_B_W-1:0] mul_b;
  logic signed [slpl_pkg::MUL_P_W-1:0] prod;

  slpl_fsm u_fsm (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  slpl_mul u_mul (
    .clk (clk),
    .en  (ctrl.mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  slpl_delay u_delay (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .len     (lookahead_len),
    .wr_en   (ctrl.finish),
    .wr_data ({r_in, l_in}),
    .rd_data (mem_rd)
  );

  assign s_tready = ctrl.in_ready;
  assign accept = s_tvalid && ctrl.in_ready;

  always_comb begin
    stat.in_valid = s_tvalid;
    stat.above = peak > threshold;
    stat.out_free = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= slpl_pkg::THRESH_RESET;
      attack_coeff <= '0;
      release_coeff <= '0;
      lookahead_len <= slpl_pkg::LOOKAHEAD_RESET;
    end else if (cfg_we) begin
      unique case (slpl_pkg::cfg_idx_t'(cfg_index))
        slpl_pkg::CFG_THRESHOLD: threshold <= cfg_data;
        slpl_pkg::CFG_ATTACK:    attack_coeff <= cfg_data[slpl_pkg::COEFF_W-1:0];
        slpl_pkg::CFG_RELEASE:   release_coeff <= cfg_data[slpl_pkg::COEFF_W-1:0];
        slpl_pkg::CFG_LOOKAHEAD: lookahead_len <= cfg_data[slpl_pkg::LEN_W-1:0];
        default:                 threshold <= threshold;
      endcase
    end
  end

  // peak magnitude, the most negative sample saturates
  always_comb begin
    mag_l = l_in[31] ? (~l_in + 32'd1) : l_in;
    mag_r = r_in[31] ? (~r_in + 32'd1) : r_in;
    sat_l = mag_l[31] ? 31'h7fff_ffff : mag_l[30:0];
    sat_r = mag_r[31] ? 31'h7fff_ffff : mag_r[30:0];
    peak_next = (sat_l > sat_r) ? sat_l : sat_r;
  end

  // leading zero search, one binary step per cycle
  always_comb begin
    shamt = 5'd16 >> ctrl.norm_step;
    top_zero = (norm >> (5'd31 - shamt)) == '0;
  end

  always_comb begin
    inv17 = prod[31:15] + slpl_pkg::HALF_Q16;
    inv = inv17[15:0];
    e = (z > 5'd7) ? z - 5'd7 : 5'd0;
    lim = 40'd1 << (5'd30 - e);
    fdiff = $signed({2'b00, prod[29:15]}) - $signed({1'b0, slpl_pkg::C085_Q15});
    delta = prod[46:15];
    sum = $signed({2'b00, sg}) + $signed({delta[31], delta});
    if (sum < 0) begin
      sg_next = '0;
    end else if (sum > $signed({2'b00, slpl_pkg::UNITY_Q30})) begin
      sg_next = slpl_pkg::UNITY_Q30;
    end else begin
      sg_next = sum[30:0];
    end
    g14 = sg[30:16];
    zero_len = lookahead_len == '0;
    dl = zero_len ? l_in : mem_rd[31:0];
    dr = zero_len ? r_in : mem_rd[63:32];
  end

  always_comb begin
    case (ctrl.mul_sel)
      slpl_pkg::MS_FRAC_C035: begin
        mul_a = $signed({18'd0, norm[29:15]});
        mul_b = $signed({9'd0, slpl_pkg::C035_Q15});
      end
      slpl_pkg::MS_FRAC_POLY: begin
        mul_a = $signed({{16{fdiff[16]}}, fdiff});
        mul_b = $signed({9'd0, norm[29:15]});
      end
      slpl_pkg::MS_THR_SCALE: begin
        mul_a = $signed({10'd0, threshold[30:8]});
        mul_b = $signed({8'd0, scaled});
      end
      slpl_pkg::MS_COEFF_DIFF: begin
        mul_a = $signed({diff[31], diff});
        mul_b = $signed({9'd0, coeff});
      end
      slpl_pkg::MS_GAIN_LEFT: begin
        mul_a = $signed({dl[31], dl});
        mul_b = $signed({9'd0, g14});
      end
      slpl_pkg::MS_GAIN_RIGHT: begin
        mul_a = $signed({dr[31], dr});
        mul_b = $signed({9'd0, g14});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      l_in <= s_tdata[31:0];
      r_in <= s_tdata[63:32];
    end
    if (ctrl.load_peak) begin
      peak <= peak_next;
      norm <= peak_next;
      z <= '0;
    end
    if (ctrl.norm && top_zero) begin
      norm <= norm << shamt;
      z <= z + shamt;
    end
    if (ctrl.check && !stat.above) begin
      tgt <= slpl_pkg::UNITY_Q30;
    end
    // right shift of the reciprocal when the peak is large
    if (ctrl.load_inv) begin
      scaled <= (z < 5'd7) ? inv >> (5'd7 - z) : inv;
    end
    if (ctrl.load_tgt) begin
      tgt <= (prod[39:0] > lim) ? slpl_pkg::UNITY_Q30 : prod[30:0] << e;
    end
    if (ctrl.load_diff) begin
      diff <= $signed({1'b0, tgt}) - $signed({1'b0, sg});
      coeff <= (tgt > sg) ? attack_coeff : release_coeff;
    end
    if (ctrl.load_left) begin
      left_res <= prod[45:14];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sg <= slpl_pkg::UNITY_Q30;
    end else if (ctrl.load_gain) begin
      sg <= sg_next;
    end
  end

  // output register, parts the two sides
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      m_tdata <= {1'b0, g14, prod[45:14], left_res};
    end
  end

  `SLPL_ASSERT_ALWAYS(a_gain_range, sg <= slpl_pkg::UNITY_Q30)
  `SLPL_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)
  `SLPL_ASSERT_IMPLY(a_target_range, ctrl.load_diff, tgt <= slpl_pkg::UNITY_Q30)
  `SLPL_ASSERT_IMPLY(a_out_gain, m_tvalid, m_tdata[78:64] <= 15'd16384)

endmodule

`default_nettype wire
